// ===== rtl/jsu_pkg.sv =====
// types, codes and helper functions shared by the json string unescape blocks
`timescale 1ns / 1ps

package jsu_pkg;

   // result kinds
   localparam logic [1:0] KIND_BYTE  = 2'd0;
   localparam logic [1:0] KIND_CLOSE = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   // error codes
   localparam logic [3:0] ERR_NONE        = 4'd0;
   localparam logic [3:0] ERR_NO_OPEN     = 4'd1;
   localparam logic [3:0] ERR_END_BODY    = 4'd2;
   localparam logic [3:0] ERR_END_ESCAPE  = 4'd3;
   localparam logic [3:0] ERR_BAD_ESCAPE  = 4'd4;
   localparam logic [3:0] ERR_CONTROL     = 4'd5;
   localparam logic [3:0] ERR_TRUNC_HEX   = 4'd6;
   localparam logic [3:0] ERR_BAD_HEX     = 4'd7;
   localparam logic [3:0] ERR_UNPAIRED_HI = 4'd8;
   localparam logic [3:0] ERR_STRAY_LO    = 4'd9;

   // characters of interest
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_B      = 8'h62;
   localparam logic [7:0] CH_F      = 8'h66;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_U      = 8'h75;
   localparam logic [7:0] CH_BS     = 8'h08;
   localparam logic [7:0] CH_FF     = 8'h0C;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_SPACE  = 8'h20;

   // top six bits of high and low surrogates
   localparam logic [5:0] SURR_HIGH = 6'b110110;
   localparam logic [5:0] SURR_LOW  = 6'b110111;

   localparam int CP_W = 21;

   typedef enum logic [2:0] {
      MODE_IDLE  = 3'd0,
      MODE_BODY  = 3'd1,
      MODE_ESC   = 3'd2,
      MODE_HEX   = 3'd3,
      MODE_WBSL  = 3'd4,
      MODE_WU    = 3'd5,
      MODE_HEXLO = 3'd6
   } mode_type;

   // one queued request outcome: a raw byte, a code point, a close or an error
   typedef struct packed {
      logic [1:0]      kind;
      logic [3:0]      err;
      logic            raw;
      logic [CP_W-1:0] value;
   } entry_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] digit;
   } hex_type;

   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type h;
      h.ok    = 1'b1;
      h.digit = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.digit = 4'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         h.digit = 4'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         h.digit = 4'(c - 8'h37);
      end else begin
         h.ok = 1'b0;
      end
      return h;
   endfunction

   // number of result items of an entry, minus one
   function automatic logic [1:0] entry_len_m1(input entry_type e);
      logic [1:0] n;
      n = 2'd0;
      if (e.kind == KIND_BYTE && !e.raw) begin
         if (e.value < 21'h80) begin
            n = 2'd0;
         end else if (e.value < 21'h800) begin
            n = 2'd1;
         end else if (e.value < 21'h10000) begin
            n = 2'd2;
         end else begin
            n = 2'd3;
         end
      end
      return n;
   endfunction

   // utf-8 byte number idx of a code point encoded in len_m1+1 bytes
   function automatic logic [7:0] utf8_piece(input logic [CP_W-1:0] v,
                                             input logic [1:0] len_m1,
                                             input logic [1:0] idx);
      logic [7:0] b;
      logic [1:0] pos;
      pos = len_m1 - idx;
      b   = v[7:0];
      if (idx == 2'd0) begin
         unique case (len_m1)
            2'd0:    b = v[7:0];
            2'd1:    b = {3'b110, v[10:6]};
            2'd2:    b = {4'b1110, v[15:12]};
            default: b = {5'b11110, v[20:18]};
         endcase
      end else begin
         unique case (pos)
            2'd0:    b = {2'b10, v[5:0]};
            2'd1:    b = {2'b10, v[11:6]};
            default: b = {2'b10, v[17:12]};
         endcase
      end
      return b;
   endfunction

endpackage

// ===== rtl/json_string_unescape_utf8.sv =====
// top level of the json string unescape to utf-8 decoder
//
//   channel   direction  handshake           payload
//   req_      in         req_valid/req_stall  in_byte, input_end
//   rsp_      out        rsp_valid/rsp_stall  result_kind, out_byte, error_code, last
//
// one request is taken per cycle while the outcome queue has room
// a request yields zero to four results; results leave one per cycle from the
// output register while rsp_stall is low, and the last digit of a \u escape yields
// up to three results, four when it completes a surrogate pair
// a result passes through the outcome queue and then the output register; the queue of QUEUE_DEPTH
// outcomes lets the parser run ahead while rsp_stall is high
// synchronous reset returns the parser to idle and empties queue and output
`timescale 1ns / 1ps

module json_string_unescape_utf8 #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_input_end,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_result_kind,
   output logic [7:0] rsp_out_byte,
   output logic [3:0] rsp_error_code,
   output logic       rsp_last
);

   jsu_pkg::entry_type push_entry, head;
   logic push, pop, empty, full, accept;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   jsu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .in_byte   (req_in_byte),
      .input_end (req_input_end),
      .push      (push),
      .entry     (push_entry)
   );

   jsu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .empty      (empty),
      .full       (full)
   );

   jsu_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .empty           (empty),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_kind (rsp_result_kind),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_error_code  (rsp_error_code),
      .rsp_last        (rsp_last)
   );

endmodule

// ===== rtl/jsu_front.sv =====
// front end: parses request bytes and queues one outcome per productive request
`timescale 1ns / 1ps

module jsu_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         in_byte,
   input  logic               input_end,
   output logic               push,
   output jsu_pkg::entry_type entry
);

   jsu_pkg::mode_type mode_ff, mode_in;
   logic [1:0]  hex_count_ff, hex_count_in;
   logic [15:0] acc_ff, acc_in;
   logic [9:0]  high_ff, high_in;

   jsu_pkg::hex_type hex;
   logic [15:0] gathered;
   logic [10:0] plane;
   logic [3:0]  err_code;
   logic        err_hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= jsu_pkg::MODE_IDLE;
         hex_count_ff <= 2'd0;
         acc_ff       <= 16'd0;
         high_ff      <= 10'd0;
      end else begin
         mode_ff      <= mode_in;
         hex_count_ff <= hex_count_in;
         acc_ff       <= acc_in;
         high_ff      <= high_in;
      end
   end

   always_comb begin
      hex      = jsu_pkg::hex_decode(in_byte);
      gathered = {acc_ff[11:0], hex.digit};
      // supplementary code point is (high + 0x40) followed by the low ten bits
      plane    = {1'b0, high_ff} + 11'h040;

      mode_in      = mode_ff;
      hex_count_in = hex_count_ff;
      acc_in       = acc_ff;
      high_in      = high_ff;
      err_code     = jsu_pkg::ERR_NONE;
      err_hit      = 1'b0;
      push         = 1'b0;
      entry.kind   = jsu_pkg::KIND_BYTE;
      entry.err    = jsu_pkg::ERR_NONE;
      entry.raw    = 1'b1;
      entry.value  = {13'd0, in_byte};

      if (accept) begin
         unique case (mode_ff)
            jsu_pkg::MODE_BODY: begin
               if (input_end) begin
                  err_hit  = 1'b1;
                  err_code = jsu_pkg::ERR_END_BODY;
               end else if (in_byte == jsu_pkg::CH_QUOTE) begin
                  mode_in    = jsu_pkg::MODE_IDLE;
                  push       = 1'b1;
                  entry.kind = jsu_pkg::KIND_CLOSE;
                  entry.value = '0;
               end else if (in_byte == jsu_pkg::CH_BSLASH) begin
                  mode_in = jsu_pkg::MODE_ESC;
               end else if (in_byte < jsu_pkg::CH_SPACE) begin
                  err_hit  = 1'b1;
                  err_code = jsu_pkg::ERR_CONTROL;
               end else begin
                  push = 1'b1;
               end
            end
            jsu_pkg::MODE_ESC: begin
               if (input_end) begin
                  err_hit  = 1'b1;
                  err_code = jsu_pkg::ERR_END_ESCAPE;
               end else begin
                  mode_in = jsu_pkg::MODE_BODY;
                  push    = 1'b1;
                  unique case (in_byte)
                     jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH: ;
                     jsu_pkg::CH_B: entry.value = {13'd0, jsu_pkg::CH_BS};
                     jsu_pkg::CH_F: entry.value = {13'd0, jsu_pkg::CH_FF};
                     jsu_pkg::CH_N: entry.value = {13'd0, jsu_pkg::CH_LF};
                     jsu_pkg::CH_R: entry.value = {13'd0, jsu_pkg::CH_CR};
                     jsu_pkg::CH_T: entry.value = {13'd0, jsu_pkg::CH_TAB};
                     jsu_pkg::CH_U: begin
                        push         = 1'b0;
                        mode_in      = jsu_pkg::MODE_HEX;
                        hex_count_in = 2'd0;
                        acc_in       = 16'd0;
                     end
                     default: begin
                        push     = 1'b0;
                        err_hit  = 1'b1;
                        err_code = jsu_pkg::ERR_BAD_ESCAPE;
                     end
                  endcase
               end
            end
            jsu_pkg::MODE_HEX, jsu_pkg::MODE_HEXLO: begin
               if (input_end) begin
                  err_hit  = 1'b1;
                  err_code = jsu_pkg::ERR_TRUNC_HEX;
               end else if (!hex.ok) begin
                  err_hit  = 1'b1;
                  err_code = jsu_pkg::ERR_BAD_HEX;
               end else if (hex_count_ff != 2'd3) begin
                  hex_count_in = hex_count_ff + 2'd1;
                  acc_in       = gathered;
               end else begin
                  hex_count_in = 2'd0;
                  acc_in       = gathered;
                  if (mode_ff == jsu_pkg::MODE_HEX) begin
                     if (gathered[15:10] == jsu_pkg::SURR_HIGH) begin
                        high_in = gathered[9:0];
                        mode_in = jsu_pkg::MODE_WBSL;
                     end else if (gathered[15:10] == jsu_pkg::SURR_LOW) begin
                        err_hit  = 1'b1;
                        err_code = jsu_pkg::ERR_STRAY_LO;
                     end else begin
                        mode_in     = jsu_pkg::MODE_BODY;
                        push        = 1'b1;
                        entry.raw   = 1'b0;
                        entry.value = {5'd0, gathered};
                     end
                  end else if (gathered[15:10] == jsu_pkg::SURR_LOW) begin
                     mode_in     = jsu_pkg::MODE_BODY;
                     push        = 1'b1;
                     entry.raw   = 1'b0;
                     entry.value = {plane, gathered[9:0]};
                  end else begin
                     err_hit  = 1'b1;
                     err_code = jsu_pkg::ERR_UNPAIRED_HI;
                  end
               end
            end
            jsu_pkg::MODE_WBSL: begin
               if (input_end || in_byte != jsu_pkg::CH_BSLASH) begin
                  err_hit  = 1'b1;
                  err_code = jsu_pkg::ERR_UNPAIRED_HI;
               end else begin
                  mode_in = jsu_pkg::MODE_WU;
               end
            end
            jsu_pkg::MODE_WU: begin
               if (input_end || in_byte != jsu_pkg::CH_U) begin
                  err_hit  = 1'b1;
                  err_code = jsu_pkg::ERR_UNPAIRED_HI;
               end else begin
                  mode_in      = jsu_pkg::MODE_HEXLO;
                  hex_count_in = 2'd0;
                  acc_in       = 16'd0;
               end
            end
            default: begin
               // idle, and any unused encoding behaves as idle
               if (input_end || in_byte != jsu_pkg::CH_QUOTE) begin
                  err_hit  = 1'b1;
                  err_code = jsu_pkg::ERR_NO_OPEN;
               end else begin
                  mode_in = jsu_pkg::MODE_BODY;
               end
            end
         endcase

         if (err_hit) begin
            mode_in      = jsu_pkg::MODE_IDLE;
            hex_count_in = 2'd0;
            acc_in       = 16'd0;
            high_in      = 10'd0;
            push         = 1'b1;
            entry.kind   = jsu_pkg::KIND_ERROR;
            entry.err    = err_code;
            entry.raw    = 1'b1;
            entry.value  = '0;
         end
      end
   end

endmodule

// ===== rtl/jsu_queue.sv =====
// small first-in first-out queue of parsed outcomes with show-ahead head
`timescale 1ns / 1ps

module jsu_queue #(
   parameter int DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  jsu_pkg::entry_type push_entry,
   input  logic               pop,
   output jsu_pkg::entry_type head,
   output logic               empty,
   output logic               full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   jsu_pkg::entry_type slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign empty   = (count_ff == CNT_W'(0));
   assign full    = (count_ff == CNT_W'(DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/jsu_back.sv =====
// back end: expands queued outcomes into result items through an output register
`timescale 1ns / 1ps

module jsu_back (
   input  logic               clock,
   input  logic               reset,
   input  jsu_pkg::entry_type head,
   input  logic               empty,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_result_kind,
   output logic [7:0]         rsp_out_byte,
   output logic [3:0]         rsp_error_code,
   output logic               rsp_last
);

   logic       valid_ff, valid_in;
   logic [1:0] idx_ff, idx_in;
   logic [1:0] kind_ff, kind_in;
   logic [7:0] byte_ff, byte_in;
   logic [3:0] err_ff, err_in;
   logic       last_ff, last_in;
   logic [1:0] len_m1;
   logic       can_load, piece_last;

   assign len_m1     = jsu_pkg::entry_len_m1(head);
   assign piece_last = (idx_ff == len_m1);
   assign can_load   = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      kind_in  = kind_ff;
      byte_in  = byte_ff;
      err_in   = err_ff;
      last_in  = last_ff;
      pop      = 1'b0;
      if (can_load) begin
         valid_in = !empty;
         if (!empty) begin
            kind_in = head.kind;
            err_in  = head.err;
            last_in = piece_last;
            byte_in = (head.kind == jsu_pkg::KIND_BYTE) ?
                      jsu_pkg::utf8_piece(head.value, len_m1, idx_ff) : 8'd0;
            if (piece_last) begin
               pop    = 1'b1;
               idx_in = 2'd0;
            end else begin
               idx_in = idx_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      byte_ff <= byte_in;
      err_ff  <= err_in;
      last_ff <= last_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_result_kind = kind_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_error_code  = err_ff;
   assign rsp_last        = last_ff;

endmodule
